>>> rtl/qau_pkg.sv
// Shared types, codes and constants of the quaternion arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package qau_pkg;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_SCALE = 3'd4,
        OP_CMP   = 3'd5
    } opcode_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam int LANES    = 4;
    localparam int ACC_BITS = 66;   // signed sum of four 64-bit products
    localparam int NRM_BITS = 65;   // sum of four squares
    localparam int REM_BITS = 66;   // divider partial remainder
    localparam int QUO_BITS = 33;   // quotient bits kept, one per divider step

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;
    localparam logic signed [ACC_BITS-1:0] ACC_MAX = 66'sd2147483647;
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = -66'sd2147483648;

    // Hamilton product: row k, term t is left[t] * right[k ^ t]; set bit = subtract
    localparam logic [3:0][3:0] HAM_NEG = {4'b0100, 4'b0010, 4'b1000, 4'b1110};

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] left_w;
        logic signed [31:0] left_x;
        logic signed [31:0] left_y;
        logic signed [31:0] left_z;
        logic signed [31:0] right_w;
        logic signed [31:0] right_x;
        logic signed [31:0] right_y;
        logic signed [31:0] right_z;
        logic signed [31:0] scale_factor;
    } in_t;

    typedef struct packed {
        logic signed [31:0] result_w;
        logic signed [31:0] result_x;
        logic signed [31:0] result_y;
        logic signed [31:0] result_z;
        logic               is_equal;
        logic [1:0]         status;
    } out_t;

    // One word in flight through the divider chain
    typedef struct packed {
        opcode_t                          op;
        logic                             eq;
        logic                             dz;
        logic                             ovf;
        logic [LANES-1:0]                 neg;
        logic [LANES-1:0]                 big;
        logic [NRM_BITS-1:0]              den;
        logic [LANES-1:0][REM_BITS-1:0]   rem;
        logic [LANES-1:0][QUO_BITS-1:0]   lq;
        logic [LANES-1:0][31:0]           res;
    } div_pkt_t;

    // {overflow, clamped value}
    function automatic logic [32:0] sat32(input logic signed [ACC_BITS-1:0] v);
        logic [32:0] r;
        if (v > ACC_MAX) begin
            r = {1'b1, SAT_MAX};
        end else if (v < ACC_MIN) begin
            r = {1'b1, SAT_MIN};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/qau_div_step.sv
// One registered restoring-division step for all four lanes.
`timescale 1ns / 1ps
`default_nettype none
module qau_div_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  qau_pkg::div_pkt_t  up,
    output logic               dn_valid,
    input  logic               dn_ready,
    output qau_pkg::div_pkt_t  dn
);
    import qau_pkg::*;

    logic     valid_reg;
    div_pkt_t pkt_reg;
    div_pkt_t pkt_next;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn       = pkt_reg;

    always_comb
    begin
        logic [REM_BITS-1:0] sh;
        logic [REM_BITS-1:0] dd;
        logic                qb;
        pkt_next = up;
        dd = {1'b0, up.den};
        for (int k = 0; k < LANES; k++)
        begin
            sh = {up.rem[k][REM_BITS-2:0], up.lq[k][QUO_BITS-1]};
            qb = (sh >= dd);
            pkt_next.rem[k] = qb ? sh - dd : sh;
            pkt_next.lq[k]  = {up.lq[k][QUO_BITS-2:0], qb};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            pkt_reg <= pkt_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/quaternion_arithmetic_unit.sv
// Top level of the pipelined quaternion arithmetic unit.
// Quaternion ALU on signed fixed point (FRAC_BITS fraction bits, Q16.16 by
// default). Each request word carries two quaternions, a real scale factor and
// an operation: add, subtract, Hamilton product, divide (left * conj(right) /
// |right|^2), scale and exact compare; each yields one response word. Products
// and quotients round toward negative infinity; out-of-range components clamp
// and report overflow, a zero divisor gives zeros and divide-by-zero status.
// Throughput: one word per clock unless rsp_ready stalls. The path from accept
// to response valid: input register, 32x32 multiplier bank, product sums,
// divide setup, 33 restoring-division steps (one quotient bit per stage, which
// sets the depth) and the output register. Every word takes the full path so
// order is kept. Each stage advances when its successor has room, so bubbles
// close up and requests keep flowing while a response waits.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  qau_pkg::in_t  req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output qau_pkg::out_t rsp
);
    import qau_pkg::*;

    localparam int NW = NRM_BITS + FRAC_BITS;   // shifted dividend width
    localparam int HW = NW - QUO_BITS;          // dividend bits above the quotient

    // ---- stage A: request register
    logic a_v_reg;
    in_t  a_reg;
    // ---- stage B: multipliers
    logic               b_v_reg;
    opcode_t            b_op_reg;
    logic               b_eq_reg;
    logic signed [63:0] b_prod_reg [LANES][LANES];
    logic signed [63:0] b_scl_reg  [LANES];
    logic [63:0]        b_sq_reg   [LANES];
    logic signed [32:0] b_add_reg  [LANES];
    // ---- stage C: sums
    logic                       c_v_reg;
    opcode_t                    c_op_reg;
    logic                       c_eq_reg;
    logic signed [ACC_BITS-1:0] c_acc_reg [LANES];
    logic [NRM_BITS-1:0]        c_nrm_reg;
    // ---- stage D: divide setup, non-divide results
    logic     d_v_reg;
    div_pkt_t d_reg;
    div_pkt_t d_next;
    // ---- divider chain
    logic     dv   [QUO_BITS+1];
    logic     drdy [QUO_BITS+1];
    div_pkt_t dp   [QUO_BITS+1];
    // ---- stage E: response register
    logic e_v_reg;
    out_t e_reg;
    out_t e_next;

    logic en_a, en_b, en_c, en_d, en_e;

    assign en_e      = !e_v_reg || rsp_ready;
    assign en_d      = !d_v_reg || drdy[0];
    assign en_c      = !c_v_reg || en_d;
    assign en_b      = !b_v_reg || en_c;
    assign en_a      = !a_v_reg || en_b;
    assign req_ready = en_a;
    assign rsp_valid = e_v_reg;
    assign rsp       = e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
        end
        else
        begin
            if (en_a) a_v_reg <= req_valid;
            if (en_b) b_v_reg <= a_v_reg;
            if (en_c) c_v_reg <= b_v_reg;
            if (en_d) d_v_reg <= c_v_reg;
            if (en_e) e_v_reg <= dv[QUO_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_reg <= req;
        end
    end

    // ---- stage B: all products in parallel
    logic signed [31:0] lv [LANES];
    logic signed [31:0] rv [LANES];
    opcode_t            a_op;

    assign a_op  = opcode_t'(a_reg.operation);
    assign lv[0] = a_reg.left_w;
    assign lv[1] = a_reg.left_x;
    assign lv[2] = a_reg.left_y;
    assign lv[3] = a_reg.left_z;
    assign rv[0] = a_reg.right_w;
    assign rv[1] = a_reg.right_x;
    assign rv[2] = a_reg.right_y;
    assign rv[3] = a_reg.right_z;

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            b_op_reg <= a_op;
            b_eq_reg <= (lv[0] == rv[0]) && (lv[1] == rv[1]) &&
                        (lv[2] == rv[2]) && (lv[3] == rv[3]);
            for (int k = 0; k < LANES; k++)
            begin
                for (int t = 0; t < LANES; t++)
                begin
                    b_prod_reg[k][t] <= 64'(lv[t]) * 64'(rv[2'(k ^ t)]);
                end
                b_scl_reg[k] <= 64'(lv[k]) * 64'(a_reg.scale_factor);
                b_sq_reg[k]  <= 64'(64'(rv[k]) * 64'(rv[k]));
                b_add_reg[k] <= (a_op == OP_SUB) ? 33'(lv[k]) - 33'(rv[k])
                                                 : 33'(lv[k]) + 33'(rv[k]);
            end
        end
    end

    // ---- stage C: signed row sums, divisor norm
    logic signed [ACC_BITS-1:0] c_acc_next [LANES];
    logic [NRM_BITS-1:0]        c_nrm_next;

    always_comb
    begin
        logic signed [ACC_BITS-1:0] sum;
        logic                       neg;
        c_nrm_next = NRM_BITS'(b_sq_reg[0]) + NRM_BITS'(b_sq_reg[1]) +
                     NRM_BITS'(b_sq_reg[2]) + NRM_BITS'(b_sq_reg[3]);
        for (int k = 0; k < LANES; k++)
        begin
            sum = '0;
            for (int t = 0; t < LANES; t++)
            begin
                // divide uses the conjugate: vector part of right negated
                neg = HAM_NEG[k][t] ^ ((b_op_reg == OP_DIV) && ((k ^ t) != 0));
                if (neg) sum = sum - ACC_BITS'(b_prod_reg[k][t]);
                else     sum = sum + ACC_BITS'(b_prod_reg[k][t]);
            end
            unique case (b_op_reg)
                OP_ADD, OP_SUB: c_acc_next[k] = ACC_BITS'(b_add_reg[k]);
                OP_MUL, OP_DIV: c_acc_next[k] = sum;
                OP_SCALE:       c_acc_next[k] = ACC_BITS'(b_scl_reg[k]);
                default:        c_acc_next[k] = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_c)
        begin
            c_op_reg  <= b_op_reg;
            c_eq_reg  <= b_eq_reg;
            c_nrm_reg <= c_nrm_next;
            for (int k = 0; k < LANES; k++)
            begin
                c_acc_reg[k] <= c_acc_next[k];
            end
        end
    end

    // ---- stage D: clamp non-divide results, seed the divider
    always_comb
    begin
        logic signed [ACC_BITS-1:0] sh;
        logic [ACC_BITS-1:0]        mag;
        logic [NW-1:0]              num;
        logic [32:0]                s;
        logic [REM_BITS-1:0]        r0;
        d_next     = '0;
        d_next.op  = c_op_reg;
        d_next.eq  = c_eq_reg;
        d_next.den = c_nrm_reg;
        d_next.dz  = (c_nrm_reg == '0);
        for (int k = 0; k < LANES; k++)
        begin
            sh = c_acc_reg[k] >>> FRAC_BITS;   // floor by the unit
            unique case (c_op_reg)
                OP_ADD, OP_SUB: s = sat32(c_acc_reg[k]);
                OP_MUL, OP_SCALE: s = sat32(sh);
                default:        s = '0;
            endcase
            d_next.res[k] = s[31:0];
            if (s[32]) d_next.ovf = 1'b1;

            d_next.neg[k] = c_acc_reg[k][ACC_BITS-1];
            mag = d_next.neg[k] ? ACC_BITS'(-c_acc_reg[k]) : ACC_BITS'(c_acc_reg[k]);
            num = {mag[NRM_BITS-1:0], {FRAC_BITS{1'b0}}};
            r0  = {{(REM_BITS-HW){1'b0}}, num[NW-1:QUO_BITS]};
            // quotient would not fit in the kept bits: clamp at the end
            d_next.big[k] = (r0 >= {1'b0, c_nrm_reg});
            d_next.rem[k] = r0;
            d_next.lq[k]  = num[QUO_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_d)
        begin
            d_reg <= d_next;
        end
    end

    assign dv[0]          = d_v_reg;
    assign dp[0]          = d_reg;
    assign drdy[QUO_BITS] = en_e;

    for (genvar j = 0; j < QUO_BITS; j++)
    begin : g_div
        qau_div_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (dv[j]),
            .up_ready (drdy[j]),
            .up       (dp[j]),
            .dn_valid (dv[j+1]),
            .dn_ready (drdy[j+1]),
            .dn       (dp[j+1])
        );
    end

    // ---- stage E: floor the quotient, clamp, form the response
    div_pkt_t fp;
    assign fp = dp[QUO_BITS];

    always_comb
    begin
        logic [31:0]         qv [LANES];
        logic                qo;
        logic [QUO_BITS:0]   qq;
        qo = 1'b0;
        for (int k = 0; k < LANES; k++)
        begin
            qq = {1'b0, fp.lq[k]} + (QUO_BITS+1)'(|fp.rem[k]);
            if (fp.big[k])
            begin
                qv[k] = fp.neg[k] ? SAT_MIN : SAT_MAX;
                qo    = 1'b1;
            end
            else if (!fp.neg[k])
            begin
                if (fp.lq[k] > QUO_BITS'(SAT_MAX))
                begin
                    qv[k] = SAT_MAX;
                    qo    = 1'b1;
                end
                else
                begin
                    qv[k] = fp.lq[k][31:0];
                end
            end
            else if (qq > (QUO_BITS+1)'(SAT_MIN))
            begin
                qv[k] = SAT_MIN;
                qo    = 1'b1;
            end
            else
            begin
                qv[k] = 32'(~qq + 1'b1);
            end
        end

        e_next = '0;
        unique case (fp.op)
            OP_DIV:
            begin
                if (fp.dz)
                begin
                    e_next.status = ST_DIV_ZERO;
                end
                else
                begin
                    e_next.result_w = qv[0];
                    e_next.result_x = qv[1];
                    e_next.result_y = qv[2];
                    e_next.result_z = qv[3];
                    e_next.status   = qo ? ST_OVERFLOW : ST_OK;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_SCALE:
            begin
                e_next.result_w = fp.res[0];
                e_next.result_x = fp.res[1];
                e_next.result_y = fp.res[2];
                e_next.result_z = fp.res[3];
                e_next.status   = fp.ovf ? ST_OVERFLOW : ST_OK;
            end
            OP_CMP:
            begin
                e_next.is_equal = fp.eq;
            end
            default:
            begin
                e_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en_e)
        begin
            e_reg <= e_next;
        end
    end

    // ---- checks
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_DIV_ZERO |->
            rsp.result_w == 0 && rsp.result_x == 0 && rsp.result_y == 0 &&
            rsp.result_z == 0 && !rsp.is_equal)
        else $error("divide by zero with nonzero result");

    a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_equal |->
            rsp.status == ST_OK && rsp.result_w == 0 && rsp.result_x == 0 &&
            rsp.result_y == 0 && rsp.result_z == 0)
        else $error("compare word carries result or status");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status == ST_OK || rsp.status == ST_DIV_ZERO ||
                      rsp.status == ST_OVERFLOW)
        else $error("illegal status code");

    a_ovf_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_OVERFLOW |->
            rsp.result_w == SAT_MAX || rsp.result_w == SAT_MIN ||
            rsp.result_x == SAT_MAX || rsp.result_x == SAT_MIN ||
            rsp.result_y == SAT_MAX || rsp.result_y == SAT_MIN ||
            rsp.result_z == SAT_MAX || rsp.result_z == SAT_MIN)
        else $error("overflow without a clamped component");

endmodule
`default_nettype wire
